### hw/rtl/glod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph outline dilation package
// Shared widths and control types for the outline dilation block.
// ----------------------------------------------------------------------------
package glod_pkg;

  // Width of one glyph row on the input side.
  localparam int unsigned RowW = 62;
  // Width of one padded output row (one column of margin on either side).
  localparam int unsigned PadW = RowW + 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned STdataW = ((RowW + 7) / 8) * 8;
  localparam int unsigned MTdataW = ((2 * PadW + 7) / 8) * 8;

  // Per-cycle controls from the sequencer to the cell row and output stage.
  typedef struct packed {
    logic shift_en;  // cells take a new row and a result is loaded
    logic zero_in;   // feed an empty row below the glyph
    logic end_row;   // this result is the last padded row of the glyph
  } glod_ctrl_t;

endpackage

### hw/rtl/glod_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph outline dilation column cell
// Holds the two previous rows of one glyph column and forms the ink and
// stroke bits of the matching padded column from its neighbors.
// ----------------------------------------------------------------------------
module glod_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_en_i,
  input  logic cur_i,
  input  logic vert_left_i,
  input  logic vert_right_i,
  output logic vert_o,
  output logic ink_o,
  output logic stroke_o
);

  logic above_q, above_d;
  logic two_above_q, two_above_d;

  // Vertical OR over the three rows of this column.
  assign vert_o   = two_above_q | above_q | cur_i;
  assign ink_o    = above_q;
  assign stroke_o = (vert_left_i | vert_o | vert_right_i) & ~above_q;

  // Move the column history down by one row on each accepted step.
  always_comb begin
    above_d     = above_q;
    two_above_d = two_above_q;
    if (shift_en_i) begin
      above_d     = cur_i;
      two_above_d = above_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q     <= 1'b0;
      two_above_q <= 1'b0;
    end else begin
      above_q     <= above_d;
      two_above_q <= two_above_d;
    end
  end

endmodule

### hw/rtl/glod_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph outline dilation sequencer
// Accepts rows while the output stage has room and runs the two extra rows
// below a glyph after its final row.
// ----------------------------------------------------------------------------
module glod_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output glod_pkg::glod_ctrl_t ctrl_o
);
  import glod_pkg::*;

  typedef enum logic [1:0] {
    ST_STREAM,
    ST_TAIL1,
    ST_TAIL2
  } state_e;

  state_e state_q, state_d;

  // Rows enter only in streaming state; the tail rows use the output slot.
  always_comb begin
    in_ready_o      = (state_q == ST_STREAM) && out_free_i;
    ctrl_o.shift_en = 1'b0;
    ctrl_o.zero_in  = 1'b0;
    ctrl_o.end_row  = 1'b0;
    state_d         = state_q;
    case (state_q)
      ST_STREAM: begin
        if (in_valid_i && out_free_i) begin
          ctrl_o.shift_en = 1'b1;
          if (in_last_i) begin
            state_d = ST_TAIL1;
          end
        end
      end
      ST_TAIL1: begin
        if (out_free_i) begin
          ctrl_o.shift_en = 1'b1;
          ctrl_o.zero_in  = 1'b1;
          state_d         = ST_TAIL2;
        end
      end
      ST_TAIL2: begin
        if (out_free_i) begin
          ctrl_o.shift_en = 1'b1;
          ctrl_o.zero_in  = 1'b1;
          ctrl_o.end_row  = 1'b1;
          state_d         = ST_STREAM;
        end
      end
      default: begin
        state_d = ST_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/glyph_outline_dilation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph outline dilation unit
// One-pixel outline of a 1-bit glyph, streamed one row per item.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one glyph row per item: tdata bit c is pixel
//   column c, tlast marks the final row of the glyph. The master channel
//   gives padded rows, one column wider on each side, with the glyph ink in
//   the low 64 bits of tdata and the outline stroke in the high 64 bits;
//   tlast marks the final padded row of the glyph.
//   A row of column cells keeps the two previous rows; each cell trades its
//   vertical OR with its neighbors, so one row passes per clock cycle while
//   the output register has room. A result is registered at the edge that
//   accepts its row. Each row gives one result; the final row gives three, in
//   the following cycles as the output register frees up, and tready stays low
//   until both extra results are loaded. After the third one the cells hold an
//   empty history for the next glyph.
//   Reset clears the row history and empties the output register.
//   While the receiver stalls the output register holds its item, and a new
//   row is taken in the same cycle that the held item leaves.
// ----------------------------------------------------------------------------
module glyph_outline_dilation_unit #(
  parameter int unsigned MAX_GLYPH_WIDTH = 62
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Fields: row_bits [61:0], zero fill [63:62].
  input  logic [glod_pkg::STdataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields: glyph_mask [63:0], stroke_mask [127:64].
  output logic [glod_pkg::MTdataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);
  import glod_pkg::*;

  glod_ctrl_t       ctrl;
  logic             out_free;
  logic [RowW-1:0]  cur_row;
  logic [RowW-1:0]  vert;
  logic [RowW-1:0]  ink;
  logic [RowW-1:0]  stroke;
  logic [PadW-1:0]  glyph_q, glyph_d;
  logic [PadW-1:0]  stroke_q, stroke_d;
  logic             end_q;
  logic             valid_q, valid_d;

  // The output slot is free when empty or when its item leaves now.
  assign out_free = !valid_q || m_axis_tready_i;

  glod_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  // Row of column cells; columns past the glyph width always see ink-free rows.
  for (genvar c = 0; c < RowW; c++) begin : g_col
    logic left_v;
    logic right_v;

    if (c < MAX_GLYPH_WIDTH) begin : g_used
      assign cur_row[c] = s_axis_tdata_i[c] & ~ctrl.zero_in;
    end else begin : g_unused
      assign cur_row[c] = 1'b0;
    end

    if (c == 0) begin : g_left_edge
      assign left_v = 1'b0;
    end else begin : g_left_inner
      assign left_v = vert[c-1];
    end

    if (c == RowW - 1) begin : g_right_edge
      assign right_v = 1'b0;
    end else begin : g_right_inner
      assign right_v = vert[c+1];
    end

    glod_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_en_i   (ctrl.shift_en),
      .cur_i        (cur_row[c]),
      .vert_left_i  (left_v),
      .vert_right_i (right_v),
      .vert_o       (vert[c]),
      .ink_o        (ink[c]),
      .stroke_o     (stroke[c])
    );
  end

  // Padded row: the margin columns carry stroke only from the edge columns.
  assign glyph_d  = {1'b0, ink, 1'b0};
  assign stroke_d = {vert[RowW-1], stroke, vert[0]};

  always_comb begin
    valid_d = valid_q;
    if (ctrl.shift_en) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (ctrl.shift_en) begin
      glyph_q  <= glyph_d;
      stroke_q <= stroke_d;
      end_q    <= ctrl.end_row;
    end
  end

  // Both padded rows fill the output payload exactly.
  assign m_axis_tdata_o  = {stroke_q, glyph_q};
  assign m_axis_tlast_o  = end_q;
  assign m_axis_tvalid_o = valid_q;

`ifndef ASSERT_OFF
  // The input is not ready right after a final row is taken.
  a_tail_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input accepted right after a final row");

  // Ink and stroke never mark the same pixel.
  a_masks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((glyph_q & stroke_q) == '0))
    else $error("glyph and stroke overlap");

  // The margin columns never carry ink.
  a_margin_no_ink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (!glyph_q[0] && !glyph_q[PadW-1]))
    else $error("ink in margin column");

  // The last padded row lies below the glyph and carries no ink.
  a_end_row_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && end_q) |-> (glyph_q == '0))
    else $error("ink on final padded row");
`endif

endmodule

### bench/glyph_outline_dilation_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph outline dilation unit testbench
// Streams glyph rows into the block and checks every padded output row, both
// masks and the end-of-glyph flag, against a row-history predictor. A short
// directed set covers empty and full rows, edge columns, the unused high bits
// of the row and single-row glyphs. Random glyphs of random height follow,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module glyph_outline_dilation_unit_test;
  import glod_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RowTarget  = 450;
  localparam int unsigned LongStall  = 300;

  // Expected padded rows and the predictor state behind them.
  class outline_scoreboard;
    typedef struct packed {
      logic [PadW-1:0] glyph;
      logic [PadW-1:0] stroke;
      logic            eog;
    } padded_row_t;

    padded_row_t     expected_rows[$];
    logic [RowW-1:0] row_above     = '0;
    logic [RowW-1:0] row_two_above = '0;
    int unsigned     fail_cnt      = 0;

    // One padded row centered on mid: ink shifted by the margin, and the
    // 3x3 dilation of the three rows with the ink taken out.
    function padded_row_t outline_row(logic [RowW-1:0] up, logic [RowW-1:0] mid,
                                      logic [RowW-1:0] down, logic eog);
      padded_row_t     r;
      logic [PadW-1:0] any_ink;
      logic [PadW-1:0] grown;
      any_ink  = {1'b0, up | mid | down, 1'b0};
      grown    = any_ink | (any_ink << 1) | (any_ink >> 1);
      r.glyph  = {1'b0, mid, 1'b0};
      r.stroke = grown & ~r.glyph;
      r.eog    = eog;
      return r;
    endfunction

    // An accepted row yields one padded row, or three on the final row.
    function void note_row(logic [RowW-1:0] row, logic is_last);
      expected_rows.push_back(outline_row(row_two_above, row_above, row, 1'b0));
      if (is_last) begin
        expected_rows.push_back(outline_row(row_above, row, '0, 1'b0));
        expected_rows.push_back(outline_row(row, '0, '0, 1'b1));
        row_above     = '0;
        row_two_above = '0;
      end else begin
        row_two_above = row_above;
        row_above     = row;
      end
    endfunction

    function void check_row(logic [MTdataW-1:0] tdata, logic tlast);
      padded_row_t want;
      if (expected_rows.size() == 0) begin
        $error("unexpected output row: tdata=%h tlast=%b", tdata, tlast);
        fail_cnt++;
        return;
      end
      want = expected_rows.pop_front();
      if (tdata[PadW-1:0] !== want.glyph) begin
        $error("glyph_mask: expected %h, got %h", want.glyph, tdata[PadW-1:0]);
        fail_cnt++;
      end
      if (tdata[2*PadW-1:PadW] !== want.stroke) begin
        $error("stroke_mask: expected %h, got %h", want.stroke, tdata[2*PadW-1:PadW]);
        fail_cnt++;
      end
      if (tlast !== want.eog) begin
        $error("end_of_glyph: expected %b, got %b", want.eog, tlast);
        fail_cnt++;
      end
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic [STdataW-1:0]  s_data  = '0;
  logic                s_last  = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready_o;
  logic [MTdataW-1:0]  m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tvalid_o;
  logic                m_ready = 1'b0;

  outline_scoreboard   sb;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         rows_sent     = 0;
  int unsigned         cycle_cnt     = 0;
  logic                stall_ask     = 1'b0;

  glyph_outline_dilation_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one row, with random gaps in front, and wait until it is taken.
  task automatic send_row(input logic [STdataW-1:0] data, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_data  <= data;
    s_last  <= is_last;
    s_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_row(data[RowW-1:0], is_last);
    rows_sent++;
  endtask

  // Row contents of varied density; the unused top bits get random values too.
  function automatic logic [STdataW-1:0] random_row();
    logic [STdataW-1:0] a;
    logic [STdataW-1:0] b;
    logic [STdataW-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return a & b & c;
      1:       return a | b | c;
      2:       return STdataW'(1) << $urandom_range(STdataW - 1);
      3:       return ($urandom_range(1) != 0) ? '1 : '0;
      default: return a;
    endcase
  endfunction

  task automatic send_glyph(input int unsigned height);
    for (int unsigned y = 0; y < height; y++) begin
      send_row(random_row(), y == height - 1);
    end
  endtask

  // Output side: check each taken item, then pick tready for the next edge.
  initial begin
    int unsigned hold_left;
    logic        stall_done;
    hold_left  = 0;
    stall_done = 1'b0;
    while (!rst_n) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) sb.check_row(m_axis_tdata_o, m_axis_tlast_o);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (stall_ask && !stall_done) begin
        stall_done = 1'b1;
        hold_left  = LongStall;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned height;
    sb = new;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed rows: full and empty single-row glyphs, the unused high bits,
    // edge columns, checkerboards and a lone pixel in a short glyph.
    send_idle_pct = 11;
    recv_idle_pct = 74;
    send_row(64'h3FFF_FFFF_FFFF_FFFF, 1'b1);
    send_row(64'h0000_0000_0000_0000, 1'b1);
    send_row(64'hC000_0000_0000_0000, 1'b1);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_row(64'h0000_0000_0000_0001, 1'b0);
    send_row(64'h2000_0000_0000_0000, 1'b0);
    send_row(64'h1555_5555_5555_5555, 1'b0);
    send_row(64'h2AAA_AAAA_AAAA_AAAA, 1'b1);
    send_row(64'h0000_0000_0000_0000, 1'b0);
    send_row(64'h0000_0000_0001_0000, 1'b0);
    send_row(64'h0000_0000_0000_0000, 1'b1);
    send_row(64'h2000_0000_0000_0001, 1'b0);
    send_row(64'h3FFF_FFFF_FFFF_FFFF, 1'b0);
    send_row(64'h0000_0000_0000_0000, 1'b0);
    send_row(64'h2000_0000_0000_0001, 1'b1);

    // Random glyphs; idle pattern changes by phase, one long output stall.
    while (rows_sent < RowTarget) begin
      if (rows_sent < RowTarget / 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 74;
      end else if (rows_sent < 2 * RowTarget / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!stall_ask) stall_ask <= 1'b1;
      end
      height = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
      send_glyph(height);
    end
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
